// ===== hw/rtl/quadratic_least_squares_fit_assert.svh =====
// Assertion macros shared by the fit block.
`ifndef QUADRATIC_LEAST_SQUARES_FIT_ASSERT_SVH
`define QUADRATIC_LEAST_SQUARES_FIT_ASSERT_SVH

// Clocked implication, disabled while reset is held.
`define QLSF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Clocked invariant, disabled while reset is held.
`define QLSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// ===== hw/rtl/qlsf_pkg.sv =====
// Package: types, constants and solve program of the quadratic fit block.
`default_nettype none
package qlsf_pkg;

  localparam int W        = 192;
  localparam int IW       = 8;
  localparam int RW       = 5;
  localparam int PCW      = 6;
  localparam int PROG_LEN = 33;
  localparam int NREG     = 20;
  localparam int QSHIFT   = 21;

  localparam logic [63:0] QMAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] QMIN = {1'b1, 63'd0};

  localparam logic [2:0] LD_LAST = 3'd7;

  localparam logic [RW-1:0] R_N    = 5'd0;
  localparam logic [RW-1:0] R_SX   = 5'd1;
  localparam logic [RW-1:0] R_SXX  = 5'd2;
  localparam logic [RW-1:0] R_SX3  = 5'd3;
  localparam logic [RW-1:0] R_SX4  = 5'd4;
  localparam logic [RW-1:0] R_SY   = 5'd5;
  localparam logic [RW-1:0] R_SYX  = 5'd6;
  localparam logic [RW-1:0] R_SYX2 = 5'd7;
  localparam logic [RW-1:0] R_T0   = 5'd8;
  localparam logic [RW-1:0] R_T1   = 5'd9;
  localparam logic [RW-1:0] R_D1   = 5'd10;
  localparam logic [RW-1:0] R_D2   = 5'd11;
  localparam logic [RW-1:0] R_D3   = 5'd12;
  localparam logic [RW-1:0] R_D4   = 5'd13;
  localparam logic [RW-1:0] R_D5   = 5'd14;
  localparam logic [RW-1:0] R_DEN  = 5'd15;
  localparam logic [RW-1:0] R_NA   = 5'd16;
  localparam logic [RW-1:0] R_NB   = 5'd17;
  localparam logic [RW-1:0] R_NC   = 5'd18;
  localparam logic [RW-1:0] R_NDEN = 5'd19;

  localparam logic [RW-1:0] C_A = 5'd0;
  localparam logic [RW-1:0] C_B = 5'd1;
  localparam logic [RW-1:0] C_C = 5'd2;

  typedef enum logic [1:0] {OP_MUL, OP_SUB, OP_DIV} op_t;

  typedef enum logic [2:0] {
    S_ACC, S_DRAIN, S_LOAD, S_FETCH, S_START, S_RUN, S_WB, S_PUB
  } state_t;

  typedef struct packed {
    op_t           op;
    logic [RW-1:0] dst;
    logic [RW-1:0] sa;
    logic [RW-1:0] sb;
    logic          chk;
  } instr_t;

  typedef struct packed {
    logic          in_fire;
    logic          ld_en;
    logic [2:0]    ld_idx;
    logic          clr_sums;
    logic          rd_en;
    logic [RW-1:0] rd_a;
    logic [RW-1:0] rd_b;
    logic          start;
    op_t           op;
    logic          wb_en;
    logic [RW-1:0] wb_dst;
    logic          chk;
    logic          publish;
  } cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic unit_done;
  } st_t;

  function automatic instr_t mk(op_t op, logic [RW-1:0] d, logic [RW-1:0] a,
                                logic [RW-1:0] b, logic c);
    instr_t i;
    i.op  = op;
    i.dst = d;
    i.sa  = a;
    i.sb  = b;
    i.chk = c;
    return i;
  endfunction

  function automatic instr_t prog_f(logic [PCW-1:0] pc);
    instr_t i;
    unique case (pc)
      6'd0:  i = mk(OP_MUL, R_T0,  R_N,   R_SXX,  1'b0);
      6'd1:  i = mk(OP_MUL, R_T1,  R_SX,  R_SX,   1'b0);
      6'd2:  i = mk(OP_SUB, R_D1,  R_T0,  R_T1,   1'b1);
      6'd3:  i = mk(OP_MUL, R_T0,  R_N,   R_SX3,  1'b0);
      6'd4:  i = mk(OP_MUL, R_T1,  R_SX,  R_SXX,  1'b0);
      6'd5:  i = mk(OP_SUB, R_D2,  R_T0,  R_T1,   1'b0);
      6'd6:  i = mk(OP_MUL, R_T0,  R_N,   R_SX4,  1'b0);
      6'd7:  i = mk(OP_MUL, R_T1,  R_SXX, R_SXX,  1'b0);
      6'd8:  i = mk(OP_SUB, R_D3,  R_T0,  R_T1,   1'b0);
      6'd9:  i = mk(OP_MUL, R_T0,  R_N,   R_SYX,  1'b0);
      6'd10: i = mk(OP_MUL, R_T1,  R_SX,  R_SY,   1'b0);
      6'd11: i = mk(OP_SUB, R_D4,  R_T0,  R_T1,   1'b0);
      6'd12: i = mk(OP_MUL, R_T0,  R_N,   R_SYX2, 1'b0);
      6'd13: i = mk(OP_MUL, R_T1,  R_SXX, R_SY,   1'b0);
      6'd14: i = mk(OP_SUB, R_D5,  R_T0,  R_T1,   1'b0);
      6'd15: i = mk(OP_MUL, R_T0,  R_D1,  R_D3,   1'b0);
      6'd16: i = mk(OP_MUL, R_T1,  R_D2,  R_D2,   1'b0);
      6'd17: i = mk(OP_SUB, R_DEN, R_T0,  R_T1,   1'b1);
      6'd18: i = mk(OP_MUL, R_T0,  R_D1,  R_D5,   1'b0);
      6'd19: i = mk(OP_MUL, R_T1,  R_D2,  R_D4,   1'b0);
      6'd20: i = mk(OP_SUB, R_NA,  R_T0,  R_T1,   1'b0);
      6'd21: i = mk(OP_MUL, R_T0,  R_D3,  R_D4,   1'b0);
      6'd22: i = mk(OP_MUL, R_T1,  R_D2,  R_D5,   1'b0);
      6'd23: i = mk(OP_SUB, R_NB,  R_T0,  R_T1,   1'b0);
      6'd24: i = mk(OP_MUL, R_T0,  R_SY,  R_DEN,  1'b0);
      6'd25: i = mk(OP_MUL, R_T1,  R_SXX, R_NA,   1'b0);
      6'd26: i = mk(OP_SUB, R_NC,  R_T0,  R_T1,   1'b0);
      6'd27: i = mk(OP_MUL, R_T1,  R_SX,  R_NB,   1'b0);
      6'd28: i = mk(OP_SUB, R_NC,  R_NC,  R_T1,   1'b0);
      6'd29: i = mk(OP_MUL, R_NDEN, R_N,  R_DEN,  1'b0);
      6'd30: i = mk(OP_DIV, C_A,   R_NA,  R_DEN,  1'b0);
      6'd31: i = mk(OP_DIV, C_B,   R_NB,  R_DEN,  1'b0);
      6'd32: i = mk(OP_DIV, C_C,   R_NC,  R_NDEN, 1'b0);
      default: i = mk(OP_SUB, R_T0, R_T0, R_T0,   1'b0);
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/qlsf_datapath.sv =====
// Datapath: point accumulators, operand store, serial multiply/divide unit, result regs.
`default_nettype none
module qlsf_datapath
  import qlsf_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic signed [11:0] in_x,
  input  wire logic signed [23:0] in_y,
  input  wire cmd_t               cmd,
  output st_t                     st,
  output logic [63:0]             coef_a,
  output logic [63:0]             coef_b,
  output logic [63:0]             coef_c,
  output logic                    singular
);

  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int SX_W   = 12 + CW;
  localparam int SXX_W  = 24 + CW;
  localparam int SX3_W  = 35 + CW;
  localparam int SX4_W  = 46 + CW;
  localparam int SY_W   = 24 + CW;
  localparam int SYX_W  = 36 + CW;
  localparam int SYX2_W = 47 + CW;

  logic [CW-1:0] count_r;
  logic          v1_r, v2_r, add1_r, add2_r;
  logic signed [11:0] x1_r, x2s_r;
  logic signed [23:0] y1_r, y2_r;
  logic signed [23:0] sq1_r, sq2_r;
  logic signed [35:0] yx1_r, yx2_r;
  logic signed [34:0] cube_r;
  logic signed [45:0] quad_r;
  logic signed [46:0] yxx_r;

  logic signed [SX_W-1:0]   sum_x_r;
  logic signed [SXX_W-1:0]  sum_xx_r;
  logic signed [SX3_W-1:0]  sum_x3_r;
  logic signed [SX4_W-1:0]  sum_x4_r;
  logic signed [SY_W-1:0]   sum_y_r;
  logic signed [SYX_W-1:0]  sum_yx_r;
  logic signed [SYX2_W-1:0] sum_yx2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      v1_r <= cmd.in_fire;
      v2_r <= v1_r;
      if (cmd.clr_sums) begin
        count_r <= '0;
      end else if (cmd.in_fire && (count_r < CW'(MAX_POINTS))) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    add1_r <= count_r < CW'(MAX_POINTS);
    x1_r   <= in_x;
    y1_r   <= in_y;
    sq1_r  <= in_x * in_x;
    yx1_r  <= in_y * in_x;
    add2_r <= add1_r;
    x2s_r  <= x1_r;
    y2_r   <= y1_r;
    sq2_r  <= sq1_r;
    yx2_r  <= yx1_r;
    cube_r <= sq1_r * x1_r;
    quad_r <= sq1_r * sq1_r;
    yxx_r  <= y1_r * sq1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_sums) begin
      sum_x_r   <= '0;
      sum_xx_r  <= '0;
      sum_x3_r  <= '0;
      sum_x4_r  <= '0;
      sum_y_r   <= '0;
      sum_yx_r  <= '0;
      sum_yx2_r <= '0;
    end else if (v2_r && add2_r) begin
      sum_x_r   <= sum_x_r   + SX_W'(x2s_r);
      sum_xx_r  <= sum_xx_r  + SXX_W'(sq2_r);
      sum_x3_r  <= sum_x3_r  + SX3_W'(cube_r);
      sum_x4_r  <= sum_x4_r  + SX4_W'(quad_r);
      sum_y_r   <= sum_y_r   + SY_W'(y2_r);
      sum_yx_r  <= sum_yx_r  + SYX_W'(yx2_r);
      sum_yx2_r <= sum_yx2_r + SYX2_W'(yxx_r);
    end
  end

  assign st.pipe_empty = !v1_r && !v2_r;

  // operand store
  logic [W-1:0]  mem [NREG];
  logic [W-1:0]  opa_r, opb_r;
  logic [W-1:0]  ld_val;
  logic          mem_we;
  logic [RW-1:0] mem_wa;
  logic [W-1:0]  mem_wd;
  logic [W-1:0]  acc_r;

  always_comb begin
    unique case (cmd.ld_idx)
      3'd0:    ld_val = W'(count_r);
      3'd1:    ld_val = W'(sum_x_r);
      3'd2:    ld_val = W'(sum_xx_r);
      3'd3:    ld_val = W'(sum_x3_r);
      3'd4:    ld_val = W'(sum_x4_r);
      3'd5:    ld_val = W'(sum_y_r);
      3'd6:    ld_val = W'(sum_yx_r);
      default: ld_val = W'(sum_yx2_r);
    endcase
  end

  assign mem_we = cmd.ld_en || (cmd.wb_en && (cmd.op != OP_DIV));
  assign mem_wa = cmd.ld_en ? RW'(cmd.ld_idx) : cmd.wb_dst;
  assign mem_wd = cmd.ld_en ? ld_val : acc_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_en) begin
      opa_r <= mem[cmd.rd_a];
      opb_r <= mem[cmd.rd_b];
    end
  end

  // serial multiply / restoring divide
  logic          busy_r, done_r, neg_r;
  op_t           op_r;
  logic [IW-1:0] cnt_r;
  logic [W-1:0]  mca_r, mpb_r;
  logic [W:0]    rem_r, d2_r;
  logic [W-1:0]  mag_a, mag_b;
  logic [W:0]    rem_sh;
  logic          q_bit;

  assign mag_a  = opa_r[W-1] ? (~opa_r + 1'b1) : opa_r;
  assign mag_b  = opb_r[W-1] ? (~opb_r + 1'b1) : opb_r;
  assign rem_sh = {rem_r[W-1:0], mca_r[W-1]};
  assign q_bit  = rem_sh >= d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        cnt_r  <= '0;
        busy_r <= cmd.op != OP_SUB;
        done_r <= cmd.op == OP_SUB;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == IW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= cmd.op;
      neg_r <= opa_r[W-1] ^ opb_r[W-1];
      rem_r <= '0;
      d2_r  <= {mag_b, 1'b0};
      mpb_r <= opb_r;
      unique case (cmd.op)
        OP_SUB: begin
          acc_r <= opa_r - opb_r;
          mca_r <= opa_r;
        end
        OP_DIV: begin
          acc_r <= '0;
          mca_r <= (mag_a << QSHIFT) + mag_b;
        end
        default: begin
          acc_r <= '0;
          mca_r <= opa_r;
        end
      endcase
    end else if (busy_r) begin
      mca_r <= mca_r << 1;
      if (op_r == OP_DIV) begin
        rem_r <= q_bit ? (rem_sh - d2_r) : rem_sh;
        acc_r <= {acc_r[W-2:0], q_bit};
      end else begin
        mpb_r <= mpb_r >> 1;
        if (mpb_r[0]) begin
          acc_r <= acc_r + mca_r;
        end
      end
    end
  end

  assign st.unit_done = done_r;

  // rounding already folded into the dividend; clamp to Q32.32
  logic        q_sat;
  logic [63:0] q_val;
  assign q_sat = |acc_r[W-1:63];
  always_comb begin
    if (neg_r) begin
      q_val = q_sat ? QMIN : (~acc_r[63:0] + 1'b1);
    end else begin
      q_val = q_sat ? QMAX : acc_r[63:0];
    end
  end

  logic [63:0] cw_r [3];
  logic        sing_r;
  logic [63:0] out_a_r, out_b_r, out_c_r;
  logic        out_s_r;

  always_ff @(posedge clk) begin
    if (cmd.wb_en && (cmd.op == OP_DIV)) begin
      cw_r[cmd.wb_dst[1:0]] <= q_val;
    end
    if (cmd.ld_en && (cmd.ld_idx == 3'd0)) begin
      sing_r <= count_r == '0;
    end else if (cmd.wb_en && cmd.chk && (acc_r == '0)) begin
      sing_r <= 1'b1;
    end
    if (cmd.publish) begin
      out_a_r <= sing_r ? 64'd0 : cw_r[0];
      out_b_r <= sing_r ? 64'd0 : cw_r[1];
      out_c_r <= sing_r ? 64'd0 : cw_r[2];
      out_s_r <= sing_r;
    end
  end

  assign coef_a   = out_a_r;
  assign coef_b   = out_b_r;
  assign coef_c   = out_c_r;
  assign singular = out_s_r;

endmodule
`default_nettype wire

// ===== hw/rtl/qlsf_ctrl.sv =====
// Controller: handshake, load sequence and solve program sequencer.
`default_nettype none
`include "quadratic_least_squares_fit_assert.svh"
module qlsf_ctrl
  import qlsf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic in_tlast,
  output logic      in_tready,
  input  wire logic out_tready,
  output logic      out_tvalid,
  input  wire st_t  st,
  output cmd_t      cmd
);

  state_t         state_r, state_nxt;
  logic [PCW-1:0] pc_r;
  logic [2:0]     ld_r;
  logic           out_valid_r;
  instr_t         ins;
  logic           fire;
  logic           pc_last;

  assign ins     = prog_f(pc_r);
  assign fire    = in_tvalid && in_tready;
  assign pc_last = pc_r == PCW'(PROG_LEN - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_ACC:   if (fire && in_tlast) state_nxt = S_DRAIN;
      S_DRAIN: if (st.pipe_empty) state_nxt = S_LOAD;
      S_LOAD:  if (ld_r == LD_LAST) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_START;
      S_START: state_nxt = S_RUN;
      S_RUN:   if (st.unit_done) state_nxt = S_WB;
      S_WB:    state_nxt = pc_last ? S_PUB : S_FETCH;
      S_PUB:   if (!out_valid_r || out_tready) state_nxt = S_ACC;
      default: state_nxt = S_ACC;
    endcase
  end

  always_comb begin
    in_tready    = state_r == S_ACC;
    out_tvalid   = out_valid_r;
    cmd.in_fire  = fire;
    cmd.ld_en    = state_r == S_LOAD;
    cmd.ld_idx   = ld_r;
    cmd.clr_sums = (state_r == S_LOAD) && (ld_r == LD_LAST);
    cmd.rd_en    = state_r == S_FETCH;
    cmd.rd_a     = ins.sa;
    cmd.rd_b     = ins.sb;
    cmd.start    = state_r == S_START;
    cmd.op       = ins.op;
    cmd.wb_en    = state_r == S_WB;
    cmd.wb_dst   = ins.dst;
    cmd.chk      = ins.chk;
    cmd.publish  = (state_r == S_PUB) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      pc_r        <= '0;
      ld_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_LOAD) begin
        ld_r <= ld_r + 1'b1;
      end
      if (state_r == S_WB) begin
        pc_r <= pc_last ? '0 : pc_r + 1'b1;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `QLSF_ASSERT_IMPLY(a_wb_after_done, state_r == S_WB, $past(st.unit_done), "writeback without unit done")
  `QLSF_ASSERT_IMPLY(a_load_drained, state_r == S_LOAD, st.pipe_empty, "load while points in flight")
  `QLSF_ASSERT_ALWAYS(a_pc_range, pc_r < PCW'(PROG_LEN), "program counter out of range")

endmodule
`default_nettype wire

// ===== hw/rtl/quadratic_least_squares_fit.sv =====
// Top level: quadratic least-squares fit over a stream of (x, y) points.
//
// Input beats carry one point: x (signed integer) and y (signed Q12.12);
// in_tlast marks the last point of a set. Points are taken one per cycle
// while in_tready is high. Points past MAX_POINTS in a set are ignored, a
// last one still ends the set. After the last beat the block drains its
// 3-stage accumulate pipe, copies the sums into its operand store and runs
// a 33-step solve program on a bit-serial multiply/divide unit, where 23
// of the steps are multiplies or divides. in_tready is low during the
// solve; the throughput limit per set is that serial unit. One output beat
// per set carries a, b, c in Q32.32 (saturated) and a singular flag in
// tuser; coefficients are zero when singular.
// The result sits in an output register: a stalled receiver does not stop
// the next set from loading; only the next publish waits for it.
// Reset (rst_n low, synchronous) clears the sums, the count and out_tvalid.
`default_nettype none
module quadratic_least_squares_fit
  import qlsf_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [39:0]  in_tdata,   // x_value[11:0], y_value[35:12], zero pad
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [191:0]      out_tdata,  // coef_a[63:0], coef_b[127:64], coef_c[191:128]
  output logic              out_tuser   // singular
);

  cmd_t        cmd;
  st_t         st;
  logic [63:0] coef_a, coef_b, coef_c;

  qlsf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .st         (st),
    .cmd        (cmd)
  );

  qlsf_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_x     (in_tdata[11:0]),
    .in_y     (in_tdata[35:12]),
    .cmd      (cmd),
    .st       (st),
    .coef_a   (coef_a),
    .coef_b   (coef_b),
    .coef_c   (coef_c),
    .singular (out_tuser)
  );

  assign out_tdata = {coef_c, coef_b, coef_a};

endmodule
`default_nettype wire
